// ===== design/assert_macros.svh =====
// Assertion macros shared by the log band peak level design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define LBSPL_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define LBSPL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lbspl_pkg.sv =====
// Package with constants, types and state encodings of the log band peak level design.
`timescale 1ns / 1ps
package lbspl_pkg;

	localparam int FFT_BINS      = 1024;
	localparam int MAX_BANDS     = 128;
	localparam int MAG_FRAC_BITS = 24;

	localparam int CFG_W  = 8;
	localparam int BIN_W  = $clog2(FFT_BINS);
	localparam int EDGE_W = BIN_W + 1;
	localparam int BAND_W = $clog2(MAX_BANDS);
	localparam int CNT_W  = BAND_W + 1;
	localparam int MAG_W  = MAG_FRAC_BITS;

	localparam int LOG_SPAN   = 10;
	localparam int LOG_INT_W  = $clog2(BIN_W);
	localparam int LOG_FRAC_W = 32;
	localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
	localparam int LOG_ITER_W = $clog2(LOG_FRAC_W);
	localparam int MANT_W     = LOG_FRAC_W;
	localparam int LIM_W      = BAND_W + LOG_INT_W;
	localparam int PROD_W     = BAND_W + LOG_W;

	localparam int LEVEL_GAIN   = 765;
	localparam int LEVEL_SCALE  = LEVEL_GAIN * LEVEL_GAIN;
	localparam int SCALE_W      = $clog2(LEVEL_SCALE + 1);
	localparam int SCALED_W     = SCALE_W + MAG_W;
	localparam int RAD_W        = SCALE_W;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int REM_W        = ROOT_W + 1;
	localparam int ROOT_STEP_W  = $clog2(ROOT_W);
	localparam int LEVEL_W      = 8;
	localparam int LEVEL_OFFSET = 4;
	localparam int LEVEL_MAX    = 255;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	typedef struct packed {
		logic              we;
		logic [BAND_W-1:0] addr;
		logic [EDGE_W-1:0] data;
	} edge_wr_t;

	typedef struct packed {
		logic [BAND_W-1:0] band_index;
		logic [MAG_W-1:0]  peak;
		logic              last_band;
	} band_item_t;

	typedef enum logic [2:0] {
		B_START,
		B_PREP,
		B_LOG,
		B_MUL,
		B_CMP,
		B_WRITE,
		B_IDLE
	} build_state_t;

	typedef enum logic [1:0] {
		K_IDLE,
		K_ROOT,
		K_DONE
	} back_state_t;

endpackage

// ===== design/log_band_spectrum_peak_levels_unit.sv =====
// Top level of the log band spectrum peak level unit.
`timescale 1ns / 1ps
//
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------
// item     | item_valid / item_stall     | magnitude, frame_last
// result   | result_valid / result_stall | band_index, level, last_band
// config   | band_count_we               | band_count
//
// The front end takes one bin per cycle while the four-entry band queue has room.
// Each closed band passes through the level unit in order: a scale step, ten square root steps,
// and a load of the output register, which frees the unit while the result waits.
// After reset and after each band count write, the edge table is rebuilt with one 32-step
// logarithm per candidate bin, and item_stall stays high.
// A stalled result holds the level unit; the queue then fills and the front end stalls.
module log_band_spectrum_peak_levels_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [lbspl_pkg::MAG_W-1:0]   magnitude,
	input  logic                          frame_last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lbspl_pkg::BAND_W-1:0]  band_index,
	output logic [lbspl_pkg::LEVEL_W-1:0] level,
	output logic                          last_band,
	input  logic                          band_count_we,
	input  logic [lbspl_pkg::CFG_W-1:0]   band_count
);

	logic [lbspl_pkg::CNT_W-1:0] band_num;
	logic                        busy;
	lbspl_pkg::edge_wr_t         edge_wr;
	logic                        q_full;
	logic                        q_valid;
	logic                        push;
	logic                        pop;
	lbspl_pkg::band_item_t       push_item;
	lbspl_pkg::band_item_t       head;

	lbspl_builder u_builder (
		.clk           (clk),
		.arst_n        (arst_n),
		.band_count_we (band_count_we),
		.band_count    (band_count),
		.band_num      (band_num),
		.busy          (busy),
		.edge_wr       (edge_wr)
	);

	lbspl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.magnitude  (magnitude),
		.frame_last (frame_last),
		.busy       (busy),
		.band_num   (band_num),
		.edge_wr    (edge_wr),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	lbspl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_valid   (q_valid),
		.q_full    (q_full)
	);

	lbspl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.band_index   (band_index),
		.level        (level),
		.last_band    (last_band)
	);

endmodule

// ===== design/lbspl_builder.sv =====
// Band count register and band edge table builder with a serial base-two logarithm unit.
`timescale 1ns / 1ps
module lbspl_builder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             band_count_we,
	input  logic [lbspl_pkg::CFG_W-1:0]      band_count,
	output logic [lbspl_pkg::CNT_W-1:0]      band_num,
	output logic                             busy,
	output lbspl_pkg::edge_wr_t              edge_wr
);

	lbspl_pkg::build_state_t state_q, state_d;

	logic [lbspl_pkg::CFG_W-1:0]      band_count_q;
	logic [lbspl_pkg::BAND_W-1:0]     m;
	logic [lbspl_pkg::BAND_W-1:0]     x_q;
	logic [lbspl_pkg::BIN_W-1:0]      k_q;
	logic [lbspl_pkg::BIN_W-1:0]      cand;
	logic [lbspl_pkg::EDGE_W-1:0]     prev_q;
	logic [lbspl_pkg::LOG_INT_W-1:0]  cand_msb;
	logic [lbspl_pkg::BIN_W-1:0]      cand_norm;
	logic [lbspl_pkg::MANT_W-1:0]     mant_q;
	logic [2*lbspl_pkg::MANT_W-1:0]   sq;
	logic [lbspl_pkg::MANT_W-1:0]     mant_next;
	logic [lbspl_pkg::LOG_INT_W-1:0]  log_int_q;
	logic [lbspl_pkg::LOG_FRAC_W-1:0] log_frac_q;
	logic [lbspl_pkg::LOG_ITER_W-1:0] iter_q;
	logic [lbspl_pkg::PROD_W-1:0]     prod_q;
	logic [lbspl_pkg::LIM_W-1:0]      lim;
	logic                             fits;
	logic                             k_at_top;
	logic                             x_last;
	logic [lbspl_pkg::EDGE_W-1:0]     k_ext;
	logic [lbspl_pkg::EDGE_W-1:0]     e_raw;
	logic [lbspl_pkg::EDGE_W-1:0]     e_val;

	function automatic logic [lbspl_pkg::LOG_INT_W-1:0] msb_index(
		input logic [lbspl_pkg::BIN_W-1:0] v
	);
		logic [lbspl_pkg::LOG_INT_W-1:0] r;
		r = '0;
		for (int i = 0; i < lbspl_pkg::BIN_W; i++) begin
			if (v[i]) begin
				r = lbspl_pkg::LOG_INT_W'(i);
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= lbspl_pkg::CFG_W'(1);
		end else if (band_count_we) begin
			band_count_q <= band_count;
		end
	end

	always_comb begin
		if (band_count_q == '0) begin
			band_num = lbspl_pkg::CNT_W'(1);
		end else if (int'(band_count_q) > lbspl_pkg::MAX_BANDS) begin
			band_num = lbspl_pkg::CNT_W'(lbspl_pkg::MAX_BANDS);
		end else begin
			band_num = lbspl_pkg::CNT_W'(band_count_q);
		end
	end

	assign m         = lbspl_pkg::BAND_W'(band_num - lbspl_pkg::CNT_W'(1));
	assign cand      = k_q + lbspl_pkg::BIN_W'(1);
	assign cand_msb  = msb_index(cand);
	assign cand_norm = lbspl_pkg::BIN_W'(cand << (lbspl_pkg::LOG_INT_W'(lbspl_pkg::BIN_W - 1)
		- cand_msb));
	assign sq        = (2*lbspl_pkg::MANT_W)'(mant_q) * (2*lbspl_pkg::MANT_W)'(mant_q);
	assign mant_next = sq[2*lbspl_pkg::MANT_W-1] ? sq[2*lbspl_pkg::MANT_W-1 -: lbspl_pkg::MANT_W]
		: sq[2*lbspl_pkg::MANT_W-2 -: lbspl_pkg::MANT_W];
	assign lim       = lbspl_pkg::LIM_W'(x_q) * lbspl_pkg::LIM_W'(lbspl_pkg::LOG_SPAN);
	assign fits      = prod_q <= {lim, lbspl_pkg::LOG_FRAC_W'(0)};
	assign k_at_top  = k_q == lbspl_pkg::BIN_W'(lbspl_pkg::FFT_BINS - 1);
	assign x_last    = lbspl_pkg::CNT_W'(x_q) == lbspl_pkg::CNT_W'(band_num - lbspl_pkg::CNT_W'(1));

	always_comb begin
		k_ext = lbspl_pkg::EDGE_W'(k_q);
		e_raw = (k_ext <= prev_q) ? prev_q + lbspl_pkg::EDGE_W'(1) : k_ext;
		if (e_raw > lbspl_pkg::EDGE_W'(lbspl_pkg::FFT_BINS - 1)) begin
			e_val = lbspl_pkg::EDGE_W'(lbspl_pkg::FFT_BINS);
		end else begin
			e_val = e_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbspl_pkg::B_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		edge_wr.we   = 1'b0;
		edge_wr.addr = x_q;
		edge_wr.data = e_val;
		unique case (state_q)
			lbspl_pkg::B_START: begin
				if (band_num == lbspl_pkg::CNT_W'(1)) begin
					edge_wr.we   = 1'b1;
					edge_wr.addr = '0;
					edge_wr.data = lbspl_pkg::EDGE_W'(lbspl_pkg::FFT_BINS - 1);
					state_d      = lbspl_pkg::B_IDLE;
				end else begin
					state_d = lbspl_pkg::B_PREP;
				end
			end
			lbspl_pkg::B_PREP: begin
				state_d = k_at_top ? lbspl_pkg::B_WRITE : lbspl_pkg::B_LOG;
			end
			lbspl_pkg::B_LOG: begin
				if (iter_q == lbspl_pkg::LOG_ITER_W'(lbspl_pkg::LOG_FRAC_W - 1)) begin
					state_d = lbspl_pkg::B_MUL;
				end
			end
			lbspl_pkg::B_MUL: begin
				state_d = lbspl_pkg::B_CMP;
			end
			lbspl_pkg::B_CMP: begin
				state_d = fits ? lbspl_pkg::B_PREP : lbspl_pkg::B_WRITE;
			end
			lbspl_pkg::B_WRITE: begin
				edge_wr.we = 1'b1;
				if (x_last) begin
					state_d = lbspl_pkg::B_IDLE;
				end else if (k_at_top) begin
					state_d = lbspl_pkg::B_WRITE;
				end else begin
					state_d = lbspl_pkg::B_MUL;
				end
			end
			lbspl_pkg::B_IDLE: begin
				state_d = lbspl_pkg::B_IDLE;
			end
			default: begin
				state_d = lbspl_pkg::B_START;
			end
		endcase
		if (band_count_we) begin
			edge_wr.we = 1'b0;
			state_d    = lbspl_pkg::B_START;
		end
	end

	assign busy = state_q != lbspl_pkg::B_IDLE;

	always_ff @(posedge clk) begin
		case (state_q)
			lbspl_pkg::B_START: begin
				x_q    <= '0;
				k_q    <= lbspl_pkg::BIN_W'(1);
				prev_q <= '0;
			end
			lbspl_pkg::B_PREP: begin
				mant_q     <= {cand_norm, (lbspl_pkg::MANT_W - lbspl_pkg::BIN_W)'(0)};
				log_int_q  <= cand_msb;
				log_frac_q <= '0;
				iter_q     <= '0;
			end
			lbspl_pkg::B_LOG: begin
				mant_q     <= mant_next;
				log_frac_q <= {log_frac_q[lbspl_pkg::LOG_FRAC_W-2:0], sq[2*lbspl_pkg::MANT_W-1]};
				iter_q     <= iter_q + lbspl_pkg::LOG_ITER_W'(1);
			end
			lbspl_pkg::B_MUL: begin
				prod_q <= lbspl_pkg::PROD_W'(m) * lbspl_pkg::PROD_W'({log_int_q, log_frac_q});
			end
			lbspl_pkg::B_CMP: begin
				if (fits) begin
					k_q <= cand;
				end
			end
			lbspl_pkg::B_WRITE: begin
				prev_q <= e_val;
				x_q    <= x_q + lbspl_pkg::BAND_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/lbspl_front.sv =====
// Front end: accepts bins, tracks frame position and band peak, and queues closed bands.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbspl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [lbspl_pkg::MAG_W-1:0] magnitude,
	input  logic                        frame_last,
	input  logic                        busy,
	input  logic [lbspl_pkg::CNT_W-1:0] band_num,
	input  lbspl_pkg::edge_wr_t         edge_wr,
	input  logic                        q_full,
	output logic                        push,
	output lbspl_pkg::band_item_t       push_item
);

	logic [lbspl_pkg::EDGE_W-1:0] edge_mem_q [lbspl_pkg::MAX_BANDS];
	logic [lbspl_pkg::EDGE_W-1:0] edge_rd_q;
	logic [lbspl_pkg::BAND_W-1:0] rd_addr;

	logic [lbspl_pkg::BIN_W-1:0]  bc_q, bc_d;
	logic [lbspl_pkg::CNT_W-1:0]  cb_q, cb_d;
	logic [lbspl_pkg::MAG_W-1:0]  peak_q, peak_d;
	logic [lbspl_pkg::MAG_W-1:0]  peak_max;
	logic                         busy_d_q;
	logic                         ready;
	logic                         accept;
	logic                         closes;

	assign ready      = !busy && !busy_d_q && !q_full;
	assign item_stall = !ready;
	assign accept     = item_valid && ready;
	assign peak_max   = (magnitude > peak_q) ? magnitude : peak_q;
	assign closes     = (bc_q != '0) && (cb_q < band_num)
		&& (lbspl_pkg::EDGE_W'(bc_q) == edge_rd_q);

	always_comb begin
		bc_d                 = bc_q;
		cb_d                 = cb_q;
		peak_d               = peak_q;
		push                 = 1'b0;
		push_item.band_index = cb_q[lbspl_pkg::BAND_W-1:0];
		push_item.peak       = peak_max;
		push_item.last_band  = cb_q == lbspl_pkg::CNT_W'(band_num - lbspl_pkg::CNT_W'(1));
		if (accept) begin
			if (bc_q != '0) begin
				if (closes) begin
					push   = 1'b1;
					peak_d = '0;
					cb_d   = cb_q + lbspl_pkg::CNT_W'(1);
				end else begin
					peak_d = peak_max;
				end
			end
			if (frame_last || bc_q == lbspl_pkg::BIN_W'(lbspl_pkg::FFT_BINS - 1)) begin
				bc_d   = '0;
				cb_d   = '0;
				peak_d = '0;
			end else begin
				bc_d = bc_q + lbspl_pkg::BIN_W'(1);
			end
		end
	end

	assign rd_addr = cb_d[lbspl_pkg::BAND_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q     <= '0;
			cb_q     <= '0;
			peak_q   <= '0;
			busy_d_q <= 1'b1;
		end else begin
			bc_q     <= bc_d;
			cb_q     <= cb_d;
			peak_q   <= peak_d;
			busy_d_q <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_wr.we) begin
			edge_mem_q[edge_wr.addr] <= edge_wr.data;
		end
		edge_rd_q <= edge_mem_q[rd_addr];
	end

	`LBSPL_ASSERT_NEXT(a_frame_restart, clk, arst_n, accept && frame_last, bc_q == '0 && cb_q == '0, "frame did not restart after its last bin")

endmodule

// ===== design/lbspl_queue.sv =====
// Short queue of closed bands between the front end and the level unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbspl_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lbspl_pkg::band_item_t push_item,
	input  logic                  pop,
	output lbspl_pkg::band_item_t head,
	output logic                  q_valid,
	output logic                  q_full
);

	lbspl_pkg::band_item_t entries_q [lbspl_pkg::Q_DEPTH];

	logic [lbspl_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [lbspl_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [lbspl_pkg::Q_CNT_W-1:0] count_q;
	logic                          do_push;
	logic                          do_pop;

	assign q_valid = count_q != '0;
	assign q_full  = count_q == lbspl_pkg::Q_CNT_W'(lbspl_pkg::Q_DEPTH);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !q_full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + lbspl_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + lbspl_pkg::Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + lbspl_pkg::Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - lbspl_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	`LBSPL_ASSERT_SAME(a_q_no_overflow, clk, arst_n, push, !q_full, "band pushed into a full queue")
	`LBSPL_ASSERT_SAME(a_q_full_ptrs, clk, arst_n, q_full, wr_ptr_q == rd_ptr_q, "queue count disagrees with its pointers")

endmodule

// ===== design/lbspl_back.sv =====
// Back end: scales a band peak, takes its square root bit by bit and holds the result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lbspl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  lbspl_pkg::band_item_t         head,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lbspl_pkg::BAND_W-1:0]  band_index,
	output logic [lbspl_pkg::LEVEL_W-1:0] level,
	output logic                          last_band
);

	lbspl_pkg::back_state_t state_q, state_d;

	logic [lbspl_pkg::SCALED_W-1:0]    scaled;
	logic [lbspl_pkg::RAD_W-1:0]       rad_q;
	logic [lbspl_pkg::REM_W-1:0]       rem_q;
	logic [lbspl_pkg::ROOT_W-1:0]      root_q;
	logic [lbspl_pkg::ROOT_STEP_W-1:0] step_q;
	logic [lbspl_pkg::BAND_W-1:0]      idx_q;
	logic                              last_q;
	logic [lbspl_pkg::REM_W+1:0]       rem_sh;
	logic [lbspl_pkg::REM_W+1:0]       trial;
	logic                              ge;
	logic [lbspl_pkg::REM_W+1:0]       rem_diff;
	logic [lbspl_pkg::ROOT_W-1:0]      diff;
	logic [lbspl_pkg::LEVEL_W-1:0]     level_val;
	logic                              load;

	logic                              result_valid_q;
	logic [lbspl_pkg::BAND_W-1:0]      band_index_q;
	logic [lbspl_pkg::LEVEL_W-1:0]     level_q;
	logic                              last_band_q;

	assign scaled   = lbspl_pkg::SCALED_W'(lbspl_pkg::LEVEL_SCALE)
		* lbspl_pkg::SCALED_W'(head.peak);
	assign rem_sh   = {rem_q, rad_q[lbspl_pkg::RAD_W-1 -: 2]};
	assign trial    = (lbspl_pkg::REM_W+2)'({root_q, 2'b01});
	assign ge       = rem_sh >= trial;
	assign rem_diff = ge ? rem_sh - trial : rem_sh;
	assign diff     = root_q - lbspl_pkg::ROOT_W'(lbspl_pkg::LEVEL_OFFSET);

	always_comb begin
		if (root_q < lbspl_pkg::ROOT_W'(lbspl_pkg::LEVEL_OFFSET)) begin
			level_val = '0;
		end else if (diff > lbspl_pkg::ROOT_W'(lbspl_pkg::LEVEL_MAX)) begin
			level_val = lbspl_pkg::LEVEL_W'(lbspl_pkg::LEVEL_MAX);
		end else begin
			level_val = lbspl_pkg::LEVEL_W'(diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbspl_pkg::K_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			lbspl_pkg::K_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = lbspl_pkg::K_ROOT;
				end
			end
			lbspl_pkg::K_ROOT: begin
				if (step_q == '0) begin
					state_d = lbspl_pkg::K_DONE;
				end
			end
			lbspl_pkg::K_DONE: begin
				if (!result_valid_q || !result_stall) begin
					load    = 1'b1;
					state_d = lbspl_pkg::K_IDLE;
				end
			end
			default: begin
				state_d = lbspl_pkg::K_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lbspl_pkg::K_IDLE: begin
				rad_q  <= scaled[lbspl_pkg::SCALED_W-1 -: lbspl_pkg::RAD_W];
				idx_q  <= head.band_index;
				last_q <= head.last_band;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= lbspl_pkg::ROOT_STEP_W'(lbspl_pkg::ROOT_W - 1);
			end
			lbspl_pkg::K_ROOT: begin
				rad_q  <= {rad_q[lbspl_pkg::RAD_W-3:0], 2'b00};
				rem_q  <= rem_diff[lbspl_pkg::REM_W-1:0];
				root_q <= {root_q[lbspl_pkg::ROOT_W-2:0], ge};
				step_q <= step_q - lbspl_pkg::ROOT_STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			band_index_q <= idx_q;
			level_q      <= level_val;
			last_band_q  <= last_q;
		end
	end

	assign result_valid = result_valid_q;
	assign band_index   = band_index_q;
	assign level        = level_q;
	assign last_band    = last_band_q;

	`LBSPL_ASSERT_NEXT(a_root_ends, clk, arst_n, state_q == lbspl_pkg::K_ROOT && step_q == '0, state_q == lbspl_pkg::K_DONE, "square root did not finish after its last step")

endmodule
